### rtl/fse_pkg.sv
package fse_pkg;

   typedef enum logic [4:0] {
      CMD_LIT    = 5'd0,
      CMD_DROP   = 5'd1,
      CMD_ADD    = 5'd2,
      CMD_SUB    = 5'd3,
      CMD_MUL    = 5'd4,
      CMD_DIV    = 5'd5,
      CMD_EQ     = 5'd6,
      CMD_NE     = 5'd7,
      CMD_GT     = 5'd8,
      CMD_LT     = 5'd9,
      CMD_DEPTH  = 5'd10,
      CMD_PICK   = 5'd11,
      CMD_ROLL   = 5'd12,
      CMD_TOR    = 5'd13,
      CMD_RFROM  = 5'd14,
      CMD_RFETCH = 5'd15,
      CMD_PRINT  = 5'd16,
      CMD_EMIT   = 5'd17,
      CMD_CLEAR  = 5'd18
   } cmd_type;

   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
   localparam logic [1:0] ERR_DIV_ZERO  = 2'd3;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_NUMBER = 2'd1;
   localparam logic [1:0] KIND_CHAR   = 2'd2;

   localparam logic [31:0] TRUE_VALUE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [4:0]         cmd;
      logic signed [31:0] literal;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic [1:0]         print_kind;
      logic [6:0]         data_depth;
      logic [6:0]         return_depth;
      logic [1:0]         error_code;
   } rsp_type;

endpackage

### rtl/forth_stack_engine.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid, req_ready   fse_pkg::req_type (cmd, literal)
// rsp      out        rsp_valid, rsp_ready   fse_pkg::rsp_type (value, kind, depths, error)
//
// One item at a time: req_ready is high only while the sequencer is idle.
// Divide steps through a restoring divider, and roll reads and rewrites
// each entry that shifts down, one entry after another.
// Both stacks live in single-port-write memories with registered reads.
// Reset clears the stack counts and the state only; the result waits until rsp_ready.
module forth_stack_engine #(
   parameter int STACK_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fse_pkg::rsp_type rsp_data
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_RD1, S_RD2, S_EXEC, S_DIV, S_DIVW, S_PICK,
      S_ROLL_RD, S_ROLL_WR, S_RFROM, S_TOP, S_TOPW, S_RSP
   } state_type;

   state_type state_ff;
   logic [4:0]    cmd_ff;
   logic [31:0]   lit_ff, a_ff, b_ff, v_ff, shown_ff;
   logic [31:0]   rem_ff, quo_ff, dm_ff;
   logic          neg_ff, shown_set_ff;
   logic [4:0]    cnt_ff;
   logic [AW-1:0] i_ff;
   logic [CW-1:0] dcnt_ff, rcnt_ff;
   logic [1:0]    err_ff, kind_ff;

   logic [31:0] dmem [STACK_DEPTH];
   logic [31:0] rmem [STACK_DEPTH];
   logic [31:0] d_q_ff, r_q_ff;

   logic          d_we, r_we;
   logic [AW-1:0] d_waddr, d_raddr, r_waddr, r_raddr;
   logic [31:0]   d_wdata, r_wdata;

   logic [CW-1:0] rest;
   logic          k_bad;
   logic [AW-1:0] pos;
   logic [31:0]   alu;
   logic [32:0]   sh;
   logic          ge;
   logic [32:0]   diff;
   logic          is_bin;

   assign rest  = dcnt_ff - CW'(1);
   assign k_bad = d_q_ff[31] || (d_q_ff == 32'd0) || (d_q_ff > 32'(rest));
   assign pos   = AW'(rest - CW'(d_q_ff));
   assign sh    = {rem_ff, quo_ff[31]};
   assign diff  = sh - {1'b0, dm_ff};
   assign ge    = !diff[32];
   assign is_bin = (cmd_ff >= fse_pkg::CMD_ADD) && (cmd_ff <= fse_pkg::CMD_LT);

   always_comb begin
      case (cmd_ff)
         fse_pkg::CMD_ADD: alu = a_ff + b_ff;
         fse_pkg::CMD_SUB: alu = a_ff - b_ff;
         fse_pkg::CMD_MUL: alu = a_ff * b_ff;
         fse_pkg::CMD_EQ:  alu = (a_ff == b_ff) ? fse_pkg::TRUE_VALUE : 32'd0;
         fse_pkg::CMD_NE:  alu = (a_ff != b_ff) ? fse_pkg::TRUE_VALUE : 32'd0;
         fse_pkg::CMD_GT:  alu = ($signed(a_ff) > $signed(b_ff)) ? fse_pkg::TRUE_VALUE : 32'd0;
         fse_pkg::CMD_LT:  alu = ($signed(a_ff) < $signed(b_ff)) ? fse_pkg::TRUE_VALUE : 32'd0;
         default:          alu = 32'd0;
      endcase
   end

   always_comb begin
      d_we = 1'b0;
      d_waddr = '0;
      d_wdata = '0;
      d_raddr = '0;
      r_we = 1'b0;
      r_waddr = '0;
      r_wdata = '0;
      r_raddr = AW'(rcnt_ff - CW'(1));
      case (state_ff)
         S_CHECK: begin
            d_raddr = AW'(rest);
            if ((cmd_ff == fse_pkg::CMD_LIT || cmd_ff == fse_pkg::CMD_DEPTH)
                && dcnt_ff < FULL) begin
               d_we = 1'b1;
               d_waddr = AW'(dcnt_ff);
               d_wdata = (cmd_ff == fse_pkg::CMD_LIT) ? lit_ff : 32'(dcnt_ff);
            end
         end
         S_RD1: begin
            if (is_bin) begin
               d_raddr = AW'(dcnt_ff - CW'(2));
            end else if (cmd_ff == fse_pkg::CMD_TOR) begin
               r_we = 1'b1;
               r_waddr = AW'(rcnt_ff);
               r_wdata = d_q_ff;
            end else begin
               d_raddr = pos;
            end
         end
         S_EXEC: begin
            if (cmd_ff != fse_pkg::CMD_DIV) begin
               d_we = 1'b1;
               d_waddr = AW'(dcnt_ff - CW'(2));
               d_wdata = alu;
            end
         end
         S_DIVW: begin
            d_we = 1'b1;
            d_waddr = AW'(dcnt_ff - CW'(2));
            d_wdata = neg_ff ? -quo_ff : quo_ff;
         end
         S_PICK: begin
            if (cmd_ff == fse_pkg::CMD_PICK) begin
               d_we = 1'b1;
               d_waddr = AW'(rest);
               d_wdata = d_q_ff;
            end
         end
         S_ROLL_RD: begin
            if (CW'(i_ff) + CW'(1) < rest) begin
               d_raddr = i_ff + AW'(1);
            end else begin
               d_we = 1'b1;
               d_waddr = AW'(rest - CW'(1));
               d_wdata = v_ff;
            end
         end
         S_ROLL_WR: begin
            d_we = 1'b1;
            d_waddr = i_ff;
            d_wdata = d_q_ff;
         end
         S_RFROM: begin
            d_we = 1'b1;
            d_waddr = AW'(dcnt_ff);
            d_wdata = r_q_ff;
         end
         S_TOP: d_raddr = AW'(rest);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (d_we) dmem[d_waddr] <= d_wdata;
      d_q_ff <= dmem[d_raddr];
   end

   always_ff @(posedge clock) begin
      if (r_we) rmem[r_waddr] <= r_wdata;
      r_q_ff <= rmem[r_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dcnt_ff <= '0;
         rcnt_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req_data.cmd;
                  lit_ff <= req_data.literal;
                  err_ff <= fse_pkg::ERR_OK;
                  kind_ff <= fse_pkg::KIND_NONE;
                  shown_set_ff <= 1'b0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               state_ff <= S_TOP;
               case (cmd_ff)
                  fse_pkg::CMD_LIT, fse_pkg::CMD_DEPTH: begin
                     if (dcnt_ff >= FULL) err_ff <= fse_pkg::ERR_OVERFLOW;
                     else dcnt_ff <= dcnt_ff + CW'(1);
                  end
                  fse_pkg::CMD_DROP: begin
                     if (dcnt_ff == '0) err_ff <= fse_pkg::ERR_UNDERFLOW;
                     else dcnt_ff <= rest;
                  end
                  fse_pkg::CMD_ADD, fse_pkg::CMD_SUB, fse_pkg::CMD_MUL,
                  fse_pkg::CMD_DIV, fse_pkg::CMD_EQ, fse_pkg::CMD_NE,
                  fse_pkg::CMD_GT, fse_pkg::CMD_LT: begin
                     if (dcnt_ff < CW'(2)) err_ff <= fse_pkg::ERR_UNDERFLOW;
                     else state_ff <= S_RD1;
                  end
                  fse_pkg::CMD_PICK, fse_pkg::CMD_ROLL,
                  fse_pkg::CMD_PRINT, fse_pkg::CMD_EMIT: begin
                     if (dcnt_ff == '0) err_ff <= fse_pkg::ERR_UNDERFLOW;
                     else state_ff <= S_RD1;
                  end
                  fse_pkg::CMD_TOR: begin
                     if (dcnt_ff == '0) err_ff <= fse_pkg::ERR_UNDERFLOW;
                     else if (rcnt_ff >= FULL) err_ff <= fse_pkg::ERR_OVERFLOW;
                     else state_ff <= S_RD1;
                  end
                  fse_pkg::CMD_RFROM, fse_pkg::CMD_RFETCH: begin
                     if (rcnt_ff == '0) err_ff <= fse_pkg::ERR_UNDERFLOW;
                     else if (dcnt_ff >= FULL) err_ff <= fse_pkg::ERR_OVERFLOW;
                     else state_ff <= S_RFROM;
                  end
                  fse_pkg::CMD_CLEAR: begin
                     dcnt_ff <= '0;
                     rcnt_ff <= '0;
                  end
                  default: ;
               endcase
            end
            S_RD1: begin
               b_ff <= d_q_ff;
               if (is_bin) begin
                  state_ff <= S_RD2;
               end else if (cmd_ff == fse_pkg::CMD_TOR) begin
                  rcnt_ff <= rcnt_ff + CW'(1);
                  dcnt_ff <= rest;
                  state_ff <= S_TOP;
               end else if (cmd_ff == fse_pkg::CMD_PRINT || cmd_ff == fse_pkg::CMD_EMIT) begin
                  shown_set_ff <= 1'b1;
                  if (cmd_ff == fse_pkg::CMD_EMIT) begin
                     shown_ff <= {24'd0, d_q_ff[7:0]};
                     kind_ff <= fse_pkg::KIND_CHAR;
                  end else begin
                     shown_ff <= d_q_ff;
                     kind_ff <= fse_pkg::KIND_NUMBER;
                  end
                  dcnt_ff <= rest;
                  state_ff <= S_TOP;
               end else if (k_bad) begin
                  err_ff <= fse_pkg::ERR_UNDERFLOW;
                  state_ff <= S_TOP;
               end else begin
                  i_ff <= pos;
                  state_ff <= S_PICK;
               end
            end
            S_RD2: begin
               a_ff <= d_q_ff;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (cmd_ff != fse_pkg::CMD_DIV) begin
                  dcnt_ff <= rest;
                  state_ff <= S_TOP;
               end else if (b_ff == 32'd0) begin
                  err_ff <= fse_pkg::ERR_DIV_ZERO;
                  state_ff <= S_TOP;
               end else begin
                  rem_ff <= 32'd0;
                  quo_ff <= a_ff[31] ? -a_ff : a_ff;
                  dm_ff <= b_ff[31] ? -b_ff : b_ff;
                  neg_ff <= a_ff[31] ^ b_ff[31];
                  cnt_ff <= 5'd0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= ge ? diff[31:0] : sh[31:0];
               quo_ff <= {quo_ff[30:0], ge};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) state_ff <= S_DIVW;
            end
            S_DIVW: begin
               dcnt_ff <= rest;
               state_ff <= S_TOP;
            end
            S_PICK: begin
               v_ff <= d_q_ff;
               state_ff <= (cmd_ff == fse_pkg::CMD_PICK) ? S_TOP : S_ROLL_RD;
            end
            S_ROLL_RD: begin
               if (CW'(i_ff) + CW'(1) < rest) begin
                  state_ff <= S_ROLL_WR;
               end else begin
                  dcnt_ff <= rest;
                  state_ff <= S_TOP;
               end
            end
            S_ROLL_WR: begin
               i_ff <= i_ff + AW'(1);
               state_ff <= S_ROLL_RD;
            end
            S_RFROM: begin
               dcnt_ff <= dcnt_ff + CW'(1);
               if (cmd_ff == fse_pkg::CMD_RFROM) rcnt_ff <= rcnt_ff - CW'(1);
               state_ff <= S_TOP;
            end
            S_TOP: state_ff <= S_TOPW;
            S_TOPW: begin
               if (!shown_set_ff) shown_ff <= (dcnt_ff != '0) ? d_q_ff : 32'd0;
               state_ff <= S_RSP;
            end
            S_RSP: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_data.out_value    = shown_ff;
   assign rsp_data.print_kind   = kind_ff;
   assign rsp_data.data_depth   = 7'(dcnt_ff);
   assign rsp_data.return_depth = 7'(rcnt_ff);
   assign rsp_data.error_code   = err_ff;

endmodule
